// ===== rtl/rsi_pkg.sv =====
// shared types and constants for the ray-sphere intersection pipeline
package rsi_pkg;

   localparam int COORD_W = 32;
   localparam int A_W     = 64;
   localparam int B_W     = 65;
   localparam int C_W     = 66;
   localparam int OP_W    = 66;
   localparam int S_W     = 132;
   localparam int N_W     = 98;
   localparam int QT_W    = 36;

   typedef logic [COORD_W-1:0]         coord_type;
   typedef logic [2:0][COORD_W-1:0]    vec_type;
   typedef logic [A_W-1:0]             a_type;
   typedef logic [B_W-1:0]             b_type;
   typedef logic [C_W-1:0]             c_type;
   typedef logic [OP_W-1:0]            op_type;
   typedef logic [S_W-1:0]             s_type;
   typedef logic [N_W-1:0]             n_type;
   typedef logic [QT_W-1:0]            qt_type;

   typedef struct packed {
      logic  miss;
      b_type b;
   } bb_side_type;

   typedef struct packed {
      a_type      a;
      vec_type    o;
      vec_type    dmag;
      logic [2:0] dneg;
   } geo_side_type;

   typedef struct packed {
      logic       miss;
      b_type      b;
      a_type      a;
      vec_type    o;
      vec_type    dmag;
      logic [2:0] dneg;
   } sq_side_type;

   typedef struct packed {
      logic       miss;
      a_type      a;
      vec_type    o;
      logic [2:0] dneg;
   } nd_side_type;

   typedef struct packed {
      logic      miss;
      coord_type o;
      logic      dneg;
   } lane_side_type;

endpackage

// ===== rtl/rsi_if.sv =====
// request and response channel interfaces
interface rsi_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] origin_x;
   logic [31:0] origin_y;
   logic [31:0] origin_z;
   logic [31:0] dir_x;
   logic [31:0] dir_y;
   logic [31:0] dir_z;
   logic [31:0] center_x;
   logic [31:0] center_y;
   logic [31:0] center_z;
   logic [30:0] radius;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   center_x, center_y, center_z, radius, input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 center_x, center_y, center_z, radius, output ready);
endinterface

interface rsi_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] hit_x;
   logic [31:0] hit_y;
   logic [31:0] hit_z;

   modport source (output valid, hit, hit_x, hit_y, hit_z, input ready);
   modport sink (input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface

// ===== rtl/rsi_mul.sv =====
// two-stage wide multiplier built from four half-width partial products
module rsi_mul #(
   parameter int OP_W   = 66,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [OP_W-1:0]     op_a,
   input  logic [OP_W-1:0]     op_b,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [2*OP_W-1:0]   prod,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int H = (OP_W + 1) / 2;

   logic [2*H-1:0]    a_x, b_x;
   logic [2*H-1:0]    pll_in, plh_in, phl_in, phh_in;
   logic [2*H-1:0]    pll_ff, plh_ff, phl_ff, phh_ff;
   logic [4*H-1:0]    sum_w;
   logic [2*OP_W-1:0] prod_in, prod_ff;
   logic              v1_ff, v2_ff;
   logic [SIDE_W-1:0] side1_ff, side2_ff;

   assign a_x    = (2*H)'(op_a);
   assign b_x    = (2*H)'(op_b);
   assign pll_in = a_x[H-1:0] * b_x[H-1:0];
   assign plh_in = a_x[H-1:0] * b_x[2*H-1:H];
   assign phl_in = a_x[2*H-1:H] * b_x[H-1:0];
   assign phh_in = a_x[2*H-1:H] * b_x[2*H-1:H];

   assign sum_w = (4*H)'(pll_ff) + ((4*H)'(plh_ff) << H) + ((4*H)'(phl_ff) << H)
                + ((4*H)'(phh_ff) << (2*H));
   assign prod_in = sum_w[2*OP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pll_ff   <= pll_in;
         plh_ff   <= plh_in;
         phl_ff   <= phl_in;
         phh_ff   <= phh_in;
         side1_ff <= in_side;
         prod_ff  <= prod_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign prod      = prod_ff;
   assign out_side  = side2_ff;
endmodule

// ===== rtl/rsi_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module rsi_sqrt #(
   parameter int IN_W   = 132,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [IN_W-1:0]      radicand,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [IN_W/2-1:0]    root,
   output logic [SIDE_W-1:0]    out_side
);
   localparam int RT_W = IN_W / 2;
   localparam int R_W  = RT_W + 2;

   logic [R_W-1:0]    rem_ff  [RT_W];
   logic [RT_W-1:0]   root_ff [RT_W];
   logic [IN_W-1:0]   rad_ff  [RT_W];
   logic              vld_ff  [RT_W];
   logic [SIDE_W-1:0] side_ff [RT_W];

   for (genvar k = 0; k < RT_W; k++) begin : g_stage
      logic [R_W-1:0]    rem_cur, rem_sh, trial, rem_in;
      logic [RT_W-1:0]   root_cur, root_in;
      logic [IN_W-1:0]   rad_cur;
      logic              vld_cur;
      logic [SIDE_W-1:0] side_cur;

      if (k == 0) begin : g_first
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign rad_cur  = radicand;
         assign vld_cur  = in_valid;
         assign side_cur = in_side;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
         assign vld_cur  = vld_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      assign rem_sh = {rem_cur[R_W-3:0], rad_cur[IN_W-1 -: 2]};
      assign trial  = {root_cur, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_cur[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_cur[RT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_cur << 2;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = vld_ff[RT_W-1];
   assign root      = root_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];
endmodule

// ===== rtl/rsi_div.sv =====
// pipelined restoring divider, one quotient bit per stage, quotient saturates
module rsi_div #(
   parameter int N_W    = 98,
   parameter int D_W    = 64,
   parameter int Q_W    = 36,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [N_W-1:0]      dividend,
   input  logic [D_W-1:0]      divisor,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [Q_W-1:0]      quotient,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int CW = (N_W > D_W + Q_W - 1) ? N_W : D_W + Q_W - 1;

   logic [N_W-1:0]    rem_ff  [Q_W];
   logic [Q_W-1:0]    quo_ff  [Q_W];
   logic [D_W-1:0]    dvs_ff  [Q_W];
   logic              vld_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int SH = Q_W - 1 - k;

      logic [N_W-1:0]    rem_cur, rem_in;
      logic [Q_W-1:0]    quo_cur, quo_in;
      logic [D_W-1:0]    dvs_cur;
      logic              vld_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [CW-1:0]     rem_x, trial, diff;

      if (k == 0) begin : g_first
         assign rem_cur  = dividend;
         assign quo_cur  = '0;
         assign dvs_cur  = divisor;
         assign vld_cur  = in_valid;
         assign side_cur = in_side;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign quo_cur  = quo_ff[k-1];
         assign dvs_cur  = dvs_ff[k-1];
         assign vld_cur  = vld_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      assign rem_x = CW'(rem_cur);
      assign trial = CW'(dvs_cur) << SH;
      assign diff  = rem_x - trial;

      always_comb begin
         if (rem_x >= trial) begin
            rem_in = diff[N_W-1:0];
            quo_in = {quo_cur[Q_W-2:0], 1'b1};
         end else begin
            rem_in = rem_cur;
            quo_in = {quo_cur[Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            dvs_ff[k]  <= dvs_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign quotient  = quo_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];
endmodule

// ===== rtl/ray_sphere_intersection.sv =====
// top level of the pipelined ray-sphere intersection test
//
//   channel    direction   transaction
//   req_chan   in          origin, direction, center, radius
//   rsp_chan   out         hit flag and near intersection point
//
// one transaction enters per cycle while the output is not stalled; the pipeline
// includes the 66-stage square root and the 36-stage divider
// reset clears the valid bits of every stage, including the output valid register
// a stalled output freezes the whole pipeline; req_chan.ready follows
// rsp_chan.ready whenever the output register holds a result
module ray_sphere_intersection (
   input logic        clock,
   input logic        reset,
   rsi_req_if.sink    req_chan,
   rsi_rsp_if.source  rsp_chan
);
   logic en;
   logic out_v_ff;

   assign en             = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // stage 1: p = center - origin, magnitudes
   rsi_pkg::vec_type orig_w, dirv_w, cent_w;
   logic [2:0][32:0] p_w, pmag_w;
   rsi_pkg::vec_type dmag_w;

   assign orig_w = {req_chan.origin_z, req_chan.origin_y, req_chan.origin_x};
   assign dirv_w = {req_chan.dir_z, req_chan.dir_y, req_chan.dir_x};
   assign cent_w = {req_chan.center_z, req_chan.center_y, req_chan.center_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_w[i]    = {cent_w[i][31], cent_w[i]} - {orig_w[i][31], orig_w[i]};
         dmag_w[i] = dirv_w[i][31] ? (~dirv_w[i] + 32'd1) : dirv_w[i];
         pmag_w[i] = p_w[i][32] ? (~p_w[i] + 33'd1) : p_w[i];
      end
   end

   logic                v1_ff;
   rsi_pkg::vec_type    o1_ff, dm1_ff;
   logic [2:0]          dn1_ff, pn1_ff;
   logic [2:0][32:0]    pm1_ff;
   logic [30:0]         r1_ff;

   // stage 2: products
   logic                v2_ff;
   logic [2:0][63:0]    dd2_in, dd2_ff;
   logic [2:0][64:0]    dp2_in, dp2_ff;
   logic [2:0][65:0]    pp2_in, pp2_ff;
   logic [61:0]         rr2_in, rr2_ff;
   logic [2:0]          bs2_ff;
   rsi_pkg::vec_type    o2_ff, dm2_ff;
   logic [2:0]          dn2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd2_in[i] = rsi_pkg::a_type'(dm1_ff[i]) * rsi_pkg::a_type'(dm1_ff[i]);
         dp2_in[i] = rsi_pkg::b_type'(dm1_ff[i]) * rsi_pkg::b_type'(pm1_ff[i]);
         pp2_in[i] = rsi_pkg::c_type'(pm1_ff[i]) * rsi_pkg::c_type'(pm1_ff[i]);
      end
      rr2_in = 62'(r1_ff) * 62'(r1_ff);
   end

   // stage 3: dot products
   logic                v3_ff;
   rsi_pkg::a_type      a3_in, a3_ff;
   rsi_pkg::b_type      bpos3_in, bneg3_in, bpos3_ff, bneg3_ff;
   rsi_pkg::c_type      csum3_in, csum3_ff;
   logic [61:0]         rr3_ff;
   rsi_pkg::vec_type    o3_ff, dm3_ff;
   logic [2:0]          dn3_ff;

   always_comb begin
      a3_in    = dd2_ff[0] + dd2_ff[1] + dd2_ff[2];
      csum3_in = pp2_ff[0] + pp2_ff[1] + pp2_ff[2];
      bpos3_in = '0;
      bneg3_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (bs2_ff[i]) begin
            bneg3_in = bneg3_in + dp2_ff[i];
         end else begin
            bpos3_in = bpos3_in + dp2_ff[i];
         end
      end
   end

   // stage 4: b, c and early misses
   logic                v4_ff, miss4_ff;
   logic [65:0]         bdiff_w;
   logic [66:0]         cdiff_w;
   rsi_pkg::b_type      b4_ff;
   rsi_pkg::c_type      c4_ff;
   rsi_pkg::a_type      a4_ff;
   rsi_pkg::vec_type    o4_ff, dm4_ff;
   logic [2:0]          dn4_ff;

   assign bdiff_w = {1'b0, bpos3_ff} - {1'b0, bneg3_ff};
   assign cdiff_w = {1'b0, csum3_ff} - 67'(rr3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o1_ff  <= orig_w;
         dm1_ff <= dmag_w;
         for (int i = 0; i < 3; i++) begin
            dn1_ff[i] <= dirv_w[i][31];
            pn1_ff[i] <= p_w[i][32];
         end
         pm1_ff <= pmag_w;
         r1_ff  <= req_chan.radius;

         dd2_ff <= dd2_in;
         dp2_ff <= dp2_in;
         pp2_ff <= pp2_in;
         rr2_ff <= rr2_in;
         bs2_ff <= dn1_ff ^ pn1_ff;
         o2_ff  <= o1_ff;
         dm2_ff <= dm1_ff;
         dn2_ff <= dn1_ff;

         a3_ff    <= a3_in;
         bpos3_ff <= bpos3_in;
         bneg3_ff <= bneg3_in;
         csum3_ff <= csum3_in;
         rr3_ff   <= rr2_ff;
         o3_ff    <= o2_ff;
         dm3_ff   <= dm2_ff;
         dn3_ff   <= dn2_ff;

         miss4_ff <= (a3_ff == '0) || bdiff_w[65] || cdiff_w[66];
         b4_ff    <= bdiff_w[64:0];
         c4_ff    <= cdiff_w[65:0];
         a4_ff    <= a3_ff;
         o4_ff    <= o3_ff;
         dm4_ff   <= dm3_ff;
         dn4_ff   <= dn3_ff;
      end
   end

   // b squared and a times c
   rsi_pkg::bb_side_type  bb_side_w, bb_side_out;
   rsi_pkg::geo_side_type ac_side_w, ac_side_out;
   logic [2*rsi_pkg::OP_W-1:0] bb_prod, ac_prod;
   logic bb_valid, ac_valid;

   assign bb_side_w.miss = miss4_ff;
   assign bb_side_w.b    = b4_ff;
   assign ac_side_w.a    = a4_ff;
   assign ac_side_w.o    = o4_ff;
   assign ac_side_w.dmag = dm4_ff;
   assign ac_side_w.dneg = dn4_ff;

   rsi_mul #(
      .OP_W   (rsi_pkg::OP_W),
      .SIDE_W ($bits(rsi_pkg::bb_side_type))
   ) u_mul_bb (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .op_a      (rsi_pkg::op_type'(b4_ff)),
      .op_b      (rsi_pkg::op_type'(b4_ff)),
      .in_side   (bb_side_w),
      .out_valid (bb_valid),
      .prod      (bb_prod),
      .out_side  (bb_side_out)
   );

   rsi_mul #(
      .OP_W   (rsi_pkg::OP_W),
      .SIDE_W ($bits(rsi_pkg::geo_side_type))
   ) u_mul_ac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .op_a      (rsi_pkg::op_type'(a4_ff)),
      .op_b      (c4_ff),
      .in_side   (ac_side_w),
      .out_valid (ac_valid),
      .prod      (ac_prod),
      .out_side  (ac_side_out)
   );

   // stage 5: discriminant
   logic [132:0]         sdiff_w;
   logic                 v5_ff;
   rsi_pkg::s_type       s5_ff;
   rsi_pkg::sq_side_type sq_side_ff, sq_side_out;

   assign sdiff_w = {1'b0, bb_prod} - {1'b0, ac_prod};

   // stage 6: m = b - sqrt(s)
   logic                 sq_valid;
   logic [rsi_pkg::OP_W-1:0] root_w;
   logic                 v6_ff;
   rsi_pkg::op_type      m6_ff;
   rsi_pkg::nd_side_type nd_side_ff;
   rsi_pkg::vec_type     dm6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= bb_valid && ac_valid;
         v6_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ff           <= sdiff_w[131:0];
         sq_side_ff.miss <= bb_side_out.miss || sdiff_w[132];
         sq_side_ff.b    <= bb_side_out.b;
         sq_side_ff.a    <= ac_side_out.a;
         sq_side_ff.o    <= ac_side_out.o;
         sq_side_ff.dmag <= ac_side_out.dmag;
         sq_side_ff.dneg <= ac_side_out.dneg;

         m6_ff           <= rsi_pkg::op_type'(sq_side_out.b) - root_w;
         nd_side_ff.miss <= sq_side_out.miss;
         nd_side_ff.a    <= sq_side_out.a;
         nd_side_ff.o    <= sq_side_out.o;
         nd_side_ff.dneg <= sq_side_out.dneg;
         dm6_ff          <= sq_side_out.dmag;
      end
   end

   rsi_sqrt #(
      .IN_W   (rsi_pkg::S_W),
      .SIDE_W ($bits(rsi_pkg::sq_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .radicand  (s5_ff),
      .in_side   (sq_side_ff),
      .out_valid (sq_valid),
      .root      (root_w),
      .out_side  (sq_side_out)
   );

   // n = |d| * m per axis
   rsi_pkg::nd_side_type       nd_side_out;
   logic [2*rsi_pkg::OP_W-1:0] n_prod [3];
   logic [2:0]                 n_valid;
   logic                       n_miss1, n_miss2;

   rsi_mul #(
      .OP_W   (rsi_pkg::OP_W),
      .SIDE_W ($bits(rsi_pkg::nd_side_type))
   ) u_mul_n0 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .op_a      (rsi_pkg::op_type'(dm6_ff[0])),
      .op_b      (m6_ff),
      .in_side   (nd_side_ff),
      .out_valid (n_valid[0]),
      .prod      (n_prod[0]),
      .out_side  (nd_side_out)
   );

   rsi_mul #(
      .OP_W   (rsi_pkg::OP_W),
      .SIDE_W (1)
   ) u_mul_n1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .op_a      (rsi_pkg::op_type'(dm6_ff[1])),
      .op_b      (m6_ff),
      .in_side   (nd_side_ff.miss),
      .out_valid (n_valid[1]),
      .prod      (n_prod[1]),
      .out_side  (n_miss1)
   );

   rsi_mul #(
      .OP_W   (rsi_pkg::OP_W),
      .SIDE_W (1)
   ) u_mul_n2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .op_a      (rsi_pkg::op_type'(dm6_ff[2])),
      .op_b      (m6_ff),
      .in_side   (nd_side_ff.miss),
      .out_valid (n_valid[2]),
      .prod      (n_prod[2]),
      .out_side  (n_miss2)
   );

   // q = n / a per axis
   rsi_pkg::lane_side_type lane_side_w [3];
   rsi_pkg::lane_side_type lane_side_out [3];
   rsi_pkg::qt_type        quo_w [3];
   logic [2:0]             d_valid;
   logic [2:0]             lane_miss_w;

   assign lane_miss_w = {n_miss2, n_miss1, nd_side_out.miss};

   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign lane_side_w[i].miss = lane_miss_w[i];
      assign lane_side_w[i].o    = nd_side_out.o[i];
      assign lane_side_w[i].dneg = nd_side_out.dneg[i];

      rsi_div #(
         .N_W    (rsi_pkg::N_W),
         .D_W    (rsi_pkg::A_W),
         .Q_W    (rsi_pkg::QT_W),
         .SIDE_W ($bits(rsi_pkg::lane_side_type))
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (n_valid[i]),
         .dividend  (n_prod[i][rsi_pkg::N_W-1:0]),
         .divisor   (nd_side_out.a),
         .in_side   (lane_side_w[i]),
         .out_valid (d_valid[i]),
         .quotient  (quo_w[i]),
         .out_side  (lane_side_out[i])
      );
   end

   // output stage: origin plus offset, saturate, zero on a miss
   logic                miss_w;
   logic [2:0][37:0]    h_w;
   rsi_pkg::vec_type    hv_w;
   logic                hit_ff;
   rsi_pkg::vec_type    hv_ff;

   assign miss_w = lane_side_out[0].miss || lane_side_out[1].miss || lane_side_out[2].miss;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         h_w[i] = {{6{lane_side_out[i].o[31]}}, lane_side_out[i].o}
                + (lane_side_out[i].dneg ? (~{2'b00, quo_w[i]} + 38'd1)
                                         : {2'b00, quo_w[i]});
         if (!h_w[i][37] && (|h_w[i][36:31])) begin
            hv_w[i] = 32'h7FFF_FFFF;
         end else if (h_w[i][37] && !(&h_w[i][36:31])) begin
            hv_w[i] = 32'h8000_0000;
         end else begin
            hv_w[i] = h_w[i][31:0];
         end
         if (miss_w) begin
            hv_w[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= &d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= !miss_w;
         hv_ff  <= hv_w;
      end
   end

   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.hit   = hit_ff;
   assign rsp_chan.hit_x = hv_ff[0];
   assign rsp_chan.hit_y = hv_ff[1];
   assign rsp_chan.hit_z = hv_ff[2];
endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the ray-sphere intersection pipeline with its own wide-integer predictor
`timescale 1ns / 100ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 600;
   localparam int DRAIN_CYCLES   = 150;

   typedef logic signed [159:0] wide_type;

   typedef struct packed {
      logic [31:0] ox, oy, oz;
      logic [31:0] dx, dy, dz;
      logic [31:0] cx, cy, cz;
      logic [30:0] radius;
   } ray_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] hx, hy, hz;
   } hit_type;

   logic clock;
   logic reset;

   rsi_req_if req_if ();
   rsi_rsp_if rsp_if ();

   ray_sphere_intersection DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   hit_type expected_hits[$];
   int      errors;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_count;
   int      stall_cycles;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic hit_type predict_hit(ray_type r);
      wide_type o[3], d[3], p[3], cc[3];
      wide_type a, b, c, s, q, cand, m, dm, n, qq, h, rr;
      wide_type qmax, smax, smin;
      hit_type res;
      res = '0;
      qmax = (160'sd1 <<< 36) - 1;
      smax = 160'sd2147483647;
      smin = -160'sd2147483648;
      o[0] = $signed(r.ox); o[1] = $signed(r.oy); o[2] = $signed(r.oz);
      d[0] = $signed(r.dx); d[1] = $signed(r.dy); d[2] = $signed(r.dz);
      cc[0] = $signed(r.cx); cc[1] = $signed(r.cy); cc[2] = $signed(r.cz);
      a = 0; b = 0; c = 0;
      for (int i = 0; i < 3; i++) begin
         p[i] = cc[i] - o[i];
         a += d[i] * d[i];
         b += d[i] * p[i];
         c += p[i] * p[i];
      end
      rr = $signed({129'b0, r.radius});
      c -= rr * rr;
      if (a == 0 || b < 0 || c < 0) return res;
      s = b * b - a * c;
      if (s < 0) return res;
      q = 0;
      for (int k = 71; k >= 0; k--) begin
         cand = q | (160'sd1 <<< k);
         if (cand * cand <= s) q = cand;
      end
      m = b - q;
      res.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
         dm = d[i] < 0 ? -d[i] : d[i];
         n  = dm * m;
         qq = n / a;
         if (qq > qmax) qq = qmax;
         h = o[i] + (d[i] < 0 ? -qq : qq);
         if (h > smax) h = smax;
         if (h < smin) h = smin;
         case (i)
            0: res.hx = h[31:0];
            1: res.hy = h[31:0];
            default: res.hz = h[31:0];
         endcase
      end
      return res;
   endfunction

   // receiver side: random stalls, or a long hold-off while hold_count runs
   always @(negedge clock) begin
      if (hold_count > 0) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (hold_count > 0) hold_count <= hold_count - 1;
   end

   // response checker
   always @(posedge clock) begin
      hit_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.hit, rsp_if.hit_x, rsp_if.hit_y, rsp_if.hit_z};
         if (expected_hits.size() == 0) begin
            $display("%0t unexpected transaction exp none got %h", $time, got);
            errors++;
         end else begin
            want = expected_hits.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t hit mismatch exp %h got %h", $time, want.hit, got.hit);
               errors++;
            end
            if (got.hx !== want.hx) begin
               $display("%0t hit_x mismatch exp %h got %h", $time, want.hx, got.hx);
               errors++;
            end
            if (got.hy !== want.hy) begin
               $display("%0t hit_y mismatch exp %h got %h", $time, want.hy, got.hy);
               errors++;
            end
            if (got.hz !== want.hz) begin
               $display("%0t hit_z mismatch exp %h got %h", $time, want.hz, got.hz);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_ray(ray_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.origin_x <= r.ox; req_if.origin_y <= r.oy; req_if.origin_z <= r.oz;
      req_if.dir_x    <= r.dx; req_if.dir_y    <= r.dy; req_if.dir_z    <= r.dz;
      req_if.center_x <= r.cx; req_if.center_y <= r.cy; req_if.center_z <= r.cz;
      req_if.radius   <= r.radius;
      req_if.valid    <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      expected_hits.push_back(predict_hit(r));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_hits.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] srand(int bits);
      return 32'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
   endfunction

   function automatic ray_type make_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                        logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                        logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                        logic [30:0] radius);
      ray_type r;
      r = {ox, oy, oz, dx, dy, dz, cx, cy, cz, radius};
      return r;
   endfunction

   // ray aimed near a sphere placed ahead of the origin
   function automatic ray_type aimed_ray();
      ray_type r;
      int t;
      r.ox = srand(24); r.oy = srand(24); r.oz = srand(24);
      r.dx = srand(18); r.dy = srand(18); r.dz = srand(18);
      t = $urandom_range(0, 40);
      r.cx = r.ox + $signed(r.dx) * t + srand(17);
      r.cy = r.oy + $signed(r.dy) * t + srand(17);
      r.cz = r.oz + $signed(r.dz) * t + srand(17);
      r.radius = 31'($urandom_range(0, 1 << 22));
      return r;
   endfunction

   function automatic ray_type noise_ray();
      ray_type r;
      r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), 31'($urandom())};
      return r;
   endfunction

   function automatic ray_type random_ray();
      int sel;
      ray_type r;
      sel = $urandom_range(99);
      if (sel < 70) begin
         r = aimed_ray();
      end else if (sel < 85) begin
         r = noise_ray();
      end else begin
         r = aimed_ray();
         if (sel < 90) {r.dx, r.dy, r.dz} = '0;
         else if (sel < 95) r.radius = 31'($urandom());
         else {r.ox, r.oy, r.oz} = {r.cx, r.cy, r.cz};
      end
      return r;
   endfunction

   task automatic test_directed();
      localparam logic [31:0] ONE  = 32'h0001_0000;
      localparam logic [31:0] MAXV = 32'h7fff_ffff;
      localparam logic [31:0] MINV = 32'h8000_0000;
      send_idle_pct = 20;
      recv_idle_pct = 52;
      // zero direction
      send_ray(make_ray(0, 0, 0, 0, 0, 0, 10 * ONE, 0, 0, 31'(ONE)));
      // straight hit along each axis
      send_ray(make_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, 31'(ONE)));
      send_ray(make_ray(0, 0, 0, 0, -ONE, 0, 0, -10 * ONE, 0, 31'(2 * ONE)));
      send_ray(make_ray(ONE, ONE, ONE, 0, 0, 3 * ONE, ONE, ONE, 20 * ONE, 31'(ONE)));
      // no real root
      send_ray(make_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 5 * ONE, 0, 31'(ONE)));
      // sphere behind origin
      send_ray(make_ray(0, 0, 0, ONE, 0, 0, -10 * ONE, 0, 0, 31'(ONE)));
      // origin inside sphere
      send_ray(make_ray(0, 0, 0, ONE, 0, 0, ONE, 0, 0, 31'(3 * ONE)));
      // tangent ray
      send_ray(make_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, ONE, 0, 31'(ONE)));
      // origin on the surface
      send_ray(make_ray(0, 0, 0, ONE, 0, 0, ONE, 0, 0, 31'(ONE)));
      // zero radius through center
      send_ray(make_ray(0, 0, 0, ONE, ONE, 0, 4 * ONE, 4 * ONE, 0, 31'(0)));
      // field extremes
      send_ray(make_ray(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 31'h7fff_ffff));
      send_ray(make_ray(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MINV, MINV, 31'h7fff_ffff));
      send_ray(make_ray(MINV, 0, 0, MAXV, 0, 0, MAXV, 0, 0, 31'h7fff_ffff));
      send_ray(make_ray(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, 31'h0));
      send_ray(make_ray(0, 0, 0, 32'd1, 0, 0, MAXV, 0, 0, 31'h7fff_ffff));
      send_ray(make_ray(MINV, 0, 0, 32'd1, 0, 0, MAXV, 0, 0, 31'd1));
      // tiny direction, far sphere
      send_ray(make_ray(MINV, MINV, 0, 32'd1, 32'd1, 0, MAXV, MAXV, 0, 31'h4000_0000));
      send_ray(make_ray(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 31'h7fff_ffff));
   endtask

   task automatic test_random(int count, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) send_ray(random_ray());
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_if.valid <= 1'b0;
      @(posedge clock);
      hold_count <= HOLD_CYCLES;
      @(negedge clock);
      repeat (250) send_ray(random_ray());
      wait_drained();
      repeat (20) send_ray(random_ray());
   endtask

   initial begin
      errors        = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_count    = 0;
      stall_cycles  = 0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.origin_x = '0; req_if.origin_y = '0; req_if.origin_z = '0;
      req_if.dir_x    = '0; req_if.dir_y    = '0; req_if.dir_z    = '0;
      req_if.center_x = '0; req_if.center_y = '0; req_if.center_z = '0;
      req_if.radius   = '0;
      rsp_if.ready    = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random(180, 20, 52);
      test_random(180, 52, 20);
      test_random(180, 0, 0);
      test_backpressure();

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
